FILE: hw/rtl/oas_pkg.sv
`default_nettype none

package oas_pkg;

  localparam int unsigned MatchStartW = 32;
  localparam int unsigned MatchLenW   = 7;
  localparam int unsigned LabelW      = 6;
  localparam int unsigned ProgW       = 3;
  localparam int unsigned AddrW       = 3;
  localparam int unsigned DataW       = 32;

  localparam logic [7:0]           CharDot    = 8'h2E;
  localparam logic [7:0]           CharUpperA = 8'h41;
  localparam logic [7:0]           CharUpperZ = 8'h5A;
  localparam logic [7:0]           CharLowerA = 8'h61;
  localparam logic [7:0]           CharLowerZ = 8'h7A;
  localparam logic [7:0]           CharTwo    = 8'h32;
  localparam logic [7:0]           CharSeven  = 8'h37;
  localparam logic [7:0]           CaseBit    = 8'h20;
  localparam logic [LabelW-1:0]    RunMax     = 6'd63;
  localparam logic [MatchLenW-1:0] SuffixLen  = 7'd6;

  localparam logic [ProgW-1:0] ProgNone = 3'd0;
  localparam logic [ProgW-1:0] ProgDot  = 3'd1;
  localparam logic [ProgW-1:0] ProgLast = 3'd5;

  localparam logic RegMinLabel = 1'b0;
  localparam logic RegMaxLabel = 1'b1;

  localparam logic [LabelW-1:0] MinLabelReset = 6'd16;
  localparam logic [LabelW-1:0] MaxLabelReset = 6'd56;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       doc_first;
  } in_item_t;

  typedef struct packed {
    logic [MatchStartW-1:0] match_start;
    logic [MatchLenW-1:0]   match_length;
  } out_item_t;

  typedef struct packed {
    logic [LabelW-1:0] min_label_len;
    logic [LabelW-1:0] max_label_len;
  } cfg_t;

  // Expected letter of ".onion" for a given suffix progress value.
  function automatic logic [7:0] suffix_letter(input logic [ProgW-1:0] prog);
    logic [7:0] letter;
    case (prog)
      3'd1:    letter = 8'h6F;
      3'd2:    letter = 8'h6E;
      3'd3:    letter = 8'h69;
      3'd4:    letter = 8'h6F;
      3'd5:    letter = 8'h6E;
      default: letter = 8'h00;
    endcase
    return letter;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/oas_regs.sv
`default_nettype none

module oas_regs (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire  [oas_pkg::AddrW-1:0]  paddr,
  input  wire  [oas_pkg::DataW-1:0]  pwdata,
  output logic [oas_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output oas_pkg::cfg_t              cfg_o
);
  import oas_pkg::*;

  logic [LabelW-1:0] min_q, min_d;
  logic [LabelW-1:0] max_q, max_d;
  logic              wr_en;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (wr_en) begin
      case (reg_sel)
        RegMinLabel: min_d = pwdata[LabelW-1:0];
        RegMaxLabel: max_d = pwdata[LabelW-1:0];
        default:     min_d = min_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MinLabelReset;
      max_q <= MaxLabelReset;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  always_comb begin
    case (reg_sel)
      RegMinLabel: prdata = {{(DataW-LabelW){1'b0}}, min_q};
      RegMaxLabel: prdata = {{(DataW-LabelW){1'b0}}, max_q};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.min_label_len = min_q;
  assign cfg_o.max_label_len = max_q;

endmodule

`default_nettype wire

FILE: hw/rtl/oas_match.sv
`default_nettype none

module oas_match #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  oas_pkg::cfg_t       cfg_i,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  oas_pkg::in_item_t   in_item_i,
  input  wire                 res_free_i,
  output logic                res_valid_o,
  output oas_pkg::out_item_t  res_item_o
);
  import oas_pkg::*;

  in_item_t                s1_q;
  logic                    s1_valid_q;
  logic                    fire;

  logic [OFFSET_BITS-1:0]  offset_q, offset_d;
  logic [OFFSET_BITS-1:0]  dot_q, dot_d;
  logic [LabelW-1:0]       run_q, run_d;
  logic [LabelW-1:0]       capt_q, capt_d;
  logic [ProgW-1:0]        prog_q, prog_d;

  logic [OFFSET_BITS-1:0]  here;
  logic [OFFSET_BITS-1:0]  dot_cur;
  logic [LabelW-1:0]       run_cur;
  logic [LabelW-1:0]       capt_cur;
  logic [ProgW-1:0]        prog_cur;
  logic [7:0]              ch;
  logic                    base32;
  logic                    prog_ok;
  logic                    letter_ok;
  logic                    hit;
  logic [LabelW-1:0]       label;
  logic [OFFSET_BITS-1:0]  start_full;
  logic [OFFSET_BITS+MatchStartW-1:0] start_ext;

  // The input register moves on whenever the result side can take a result.
  assign fire       = s1_valid_q && res_free_i;
  assign in_ready_o = !s1_valid_q || res_free_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_item_i;
    end
  end

  always_comb begin
    here     = s1_q.doc_first ? '0 : offset_q;
    dot_cur  = s1_q.doc_first ? '0 : dot_q;
    run_cur  = s1_q.doc_first ? '0 : run_q;
    capt_cur = s1_q.doc_first ? '0 : capt_q;
    prog_cur = s1_q.doc_first ? ProgNone : prog_q;

    ch = s1_q.text_byte;
    if (ch >= CharUpperA && ch <= CharUpperZ) begin
      ch = ch | CaseBit;
    end
    base32 = (ch >= CharLowerA && ch <= CharLowerZ) || (ch >= CharTwo && ch <= CharSeven);

    prog_ok   = (prog_cur >= ProgDot) && (prog_cur <= ProgLast);
    letter_ok = prog_ok && (ch == suffix_letter(prog_cur));
    hit       = letter_ok && (prog_cur == ProgLast);

    label      = (capt_cur > cfg_i.max_label_len) ? cfg_i.max_label_len : capt_cur;
    start_full = dot_cur - OFFSET_BITS'(label);
    start_ext  = {{MatchStartW{1'b0}}, start_full};

    offset_d = here + OFFSET_BITS'(1);
    run_d    = run_cur;
    capt_d   = capt_cur;
    dot_d    = dot_cur;
    prog_d   = prog_cur;

    if (hit) begin
      run_d  = '0;
      prog_d = ProgNone;
    end else begin
      prog_d = letter_ok ? prog_cur + ProgW'(1) : ProgNone;
      if (base32) begin
        if (run_cur != RunMax) begin
          run_d = run_cur + LabelW'(1);
        end
      end else begin
        if (ch == CharDot && run_cur >= cfg_i.min_label_len &&
            cfg_i.max_label_len >= cfg_i.min_label_len) begin
          capt_d = run_cur;
          dot_d  = here;
          prog_d = ProgDot;
        end
        run_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      dot_q    <= '0;
      run_q    <= '0;
      capt_q   <= '0;
      prog_q   <= ProgNone;
    end else if (fire) begin
      offset_q <= offset_d;
      dot_q    <= dot_d;
      run_q    <= run_d;
      capt_q   <= capt_d;
      prog_q   <= prog_d;
    end
  end

  assign res_valid_o             = fire && hit;
  assign res_item_o.match_start  = start_ext[MatchStartW-1:0];
  assign res_item_o.match_length = {1'b0, label} + SuffixLen;

  a_prog_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prog_q <= ProgLast)
    else $error("suffix progress out of range");

  a_first_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && s1_q.doc_first |=> offset_q == OFFSET_BITS'(1))
    else $error("document start did not restart the offset");

  a_match_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> run_q == '0 && prog_q == ProgNone)
    else $error("matcher not cleared after a match");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_item_o.match_length <= {1'b0, cfg_i.max_label_len} + SuffixLen)
    else $error("match length above the configured maximum");

endmodule

`default_nettype wire

FILE: hw/rtl/oas_outbuf.sv
`default_nettype none

module oas_outbuf (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 res_valid_i,
  input  oas_pkg::out_item_t  res_item_i,
  output logic                res_free_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output oas_pkg::out_item_t  out_item_o
);
  import oas_pkg::*;

  logic      valid_q;
  out_item_t item_q;

  assign res_free_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_free_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free_o && res_valid_i) begin
      item_q <= res_item_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/onion_address_scanner.sv
// Finds addresses of the form [a-z2-7]{min,max}.onion, letters in either
// case, in a byte stream and reports the start offset and total length of
// each match. One byte item is accepted per clock cycle while the result
// register is empty or out_ready_i is high. A match passes the input
// register, the combinational matcher and the result register, in that
// order. Raising doc_first with a byte restarts the offset and matcher at
// that byte. Configuration registers are min_label_len at address 0 and
// max_label_len at address 4; write them only while no item is in flight.
`default_nettype none

module onion_address_scanner #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire  [oas_pkg::AddrW-1:0]  paddr,
  input  wire  [oas_pkg::DataW-1:0]  pwdata,
  output logic [oas_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  oas_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output oas_pkg::out_item_t         out_item_o
);
  import oas_pkg::*;

  cfg_t      cfg;
  logic      res_valid;
  logic      res_free;
  out_item_t res_item;

  oas_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  oas_match #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_item_o  (res_item)
  );

  oas_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_item_i  (res_item),
    .res_free_o  (res_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
